@@ rtl/lsc_pkg.sv @@
// shared types and constants for the line segment clipper
package lsc_pkg;

  localparam int COORD_BITS = 16;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COORD_BITS:0]   delta_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } seg_t;

  typedef struct packed {
    logic   visible;
    coord_t clip_start_x;
    coord_t clip_start_y;
    coord_t clip_end_x;
    coord_t clip_end_y;
  } clip_t;

  typedef struct packed {
    coord_t left;
    coord_t right;
    coord_t bottom;
    coord_t top;
  } window_t;

  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_RIGHT  = 2'd1,
    REG_BOTTOM = 2'd2,
    REG_TOP    = 2'd3
  } reg_idx_t;

  // one divider operand pair: numerator sign, magnitude and divisor
  typedef struct packed {
    logic                  neg;
    logic [COORD_BITS-1:0] num;
    logic [COORD_BITS-1:0] den;
  } lane_t;

  typedef struct packed {
    coord_t start;
    delta_t delta;
    logic   par;
  } axis_side_t;

  typedef struct packed {
    axis_side_t x;
    axis_side_t y;
    logic       par_ok;
  } side_t;

endpackage

@@ rtl/lsc_front.sv @@
// first stage: deltas, boundary distances and parallel-axis test
module lsc_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           seg_valid,
  input  lsc_pkg::seg_t  seg,
  input  lsc_pkg::window_t win,
  output logic           valid,
  output lsc_pkg::side_t side,
  output lsc_pkg::lane_t ax,
  output lsc_pkg::lane_t bx,
  output lsc_pkg::lane_t ay,
  output lsc_pkg::lane_t by
);
  import lsc_pkg::*;

  typedef struct packed {
    lane_t      a;
    lane_t      b;
    axis_side_t side;
    logic       in_slab;
  } axis_out_t;

  function automatic axis_out_t calc_axis(coord_t s, coord_t e, coord_t lo, coord_t hi);
    axis_out_t r;
    delta_t    d;
    delta_t    lo_m_s;
    delta_t    hi_m_s;
    delta_t    na;
    delta_t    nb;
    delta_t    den;
    d      = {e[COORD_BITS-1], e} - {s[COORD_BITS-1], s};
    lo_m_s = {lo[COORD_BITS-1], lo} - {s[COORD_BITS-1], s};
    hi_m_s = {hi[COORD_BITS-1], hi} - {s[COORD_BITS-1], s};
    if (d[COORD_BITS]) begin
      na  = -hi_m_s;
      nb  = -lo_m_s;
      den = -d;
    end else begin
      na  = lo_m_s;
      nb  = hi_m_s;
      den = d;
    end
    r.a.neg      = na[COORD_BITS];
    r.a.num      = na[COORD_BITS-1:0];
    r.a.den      = den[COORD_BITS-1:0];
    r.b.neg      = nb[COORD_BITS];
    r.b.num      = nb[COORD_BITS-1:0];
    r.b.den      = den[COORD_BITS-1:0];
    r.side.start = s;
    r.side.delta = d;
    r.side.par   = (d == '0);
    r.in_slab    = !(s < lo || s > hi);
    return r;
  endfunction

  axis_out_t xa;
  axis_out_t ya;

  always_comb begin
    xa = calc_axis(seg.start_x, seg.end_x, win.left, win.right);
    ya = calc_axis(seg.start_y, seg.end_y, win.bottom, win.top);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= seg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side.x      <= xa.side;
      side.y      <= ya.side;
      // an axis with zero delta must hold the start inside its slab
      side.par_ok <= (!xa.side.par || xa.in_slab) && (!ya.side.par || ya.in_slab);
      ax          <= xa.a;
      bx          <= xa.b;
      ay          <= ya.a;
      by          <= ya.b;
    end
  end

endmodule

@@ rtl/lsc_div.sv @@
// pipelined restoring divider, one quotient bit per stage, saturating above 1.0
module lsc_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        en,
  input  lsc_pkg::lane_t              lane,
  output logic signed [FRAC_BITS+1:0] t
);
  import lsc_pkg::*;

  localparam int QW = FRAC_BITS + 1;
  localparam int TW = FRAC_BITS + 2;
  localparam logic [QW-1:0] Q_ONE = QW'(1) << FRAC_BITS;

  logic [COORD_BITS-1:0] rem [0:FRAC_BITS];
  logic [COORD_BITS-1:0] den [0:FRAC_BITS];
  logic [QW-1:0]         quo [0:FRAC_BITS];
  logic                  sat [0:FRAC_BITS];
  logic                  neg [0:FRAC_BITS];

  logic                  ge0;
  logic                  sat0;

  always_comb begin
    sat0 = {1'b0, lane.num} >= {lane.den, 1'b0};
    ge0  = lane.num >= lane.den;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= ge0 ? lane.num - lane.den : lane.num;
      den[0] <= lane.den;
      quo[0] <= {{(QW-1){1'b0}}, ge0};
      sat[0] <= sat0;
      neg[0] <= lane.neg;
    end
  end

  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_step
    logic [COORD_BITS:0] r2;
    logic                ge;
    always_comb begin
      r2 = {rem[k-1], 1'b0};
      ge = r2 >= {1'b0, den[k-1]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? COORD_BITS'(r2 - {1'b0, den[k-1]}) : r2[COORD_BITS-1:0];
        den[k] <= den[k-1];
        quo[k] <= {quo[k-1][QW-2:0], ge};
        sat[k] <= sat[k-1];
        neg[k] <= neg[k-1];
      end
    end
  end

  always_comb begin
    if (neg[FRAC_BITS]) begin
      t = '1;
    end else if (sat[FRAC_BITS] || quo[FRAC_BITS] > Q_ONE) begin
      t = TW'(Q_ONE) + TW'(1);
    end else begin
      t = TW'(quo[FRAC_BITS]);
    end
  end

endmodule

@@ rtl/lsc_delay.sv @@
// side data delay line matching the divider depth
module lsc_delay #(
  parameter int DEPTH = 17
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  lsc_pkg::side_t in_side,
  output logic           out_valid,
  output lsc_pkg::side_t out_side
);
  import lsc_pkg::*;

  logic  vld  [0:DEPTH-1];
  side_t data [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i < DEPTH; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data[0] <= in_side;
      for (int i = 1; i < DEPTH; i++) data[i] <= data[i-1];
    end
  end

  assign out_valid = vld[DEPTH-1];
  assign out_side  = data[DEPTH-1];

endmodule

@@ rtl/lsc_back.sv @@
// bound merge, interpolation multiply and rounding into the output register
module lsc_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  lsc_pkg::side_t              side,
  input  logic signed [FRAC_BITS+1:0] ta_x,
  input  logic signed [FRAC_BITS+1:0] tb_x,
  input  logic signed [FRAC_BITS+1:0] ta_y,
  input  logic signed [FRAC_BITS+1:0] tb_y,
  output logic                        out_valid,
  output lsc_pkg::clip_t              out
);
  import lsc_pkg::*;

  localparam int TW = FRAC_BITS + 2;
  localparam int PW = FRAC_BITS + COORD_BITS + 3;
  localparam logic signed [TW-1:0] T_ONE = TW'(1) << FRAC_BITS;
  localparam logic signed [PW-1:0] T_HALF = PW'(1) << (FRAC_BITS - 1);

  // merge stage
  logic signed [TW-1:0] t_in_c;
  logic signed [TW-1:0] t_out_c;
  logic                 ok_c;

  logic                 m_valid;
  side_t                m_side;
  logic [FRAC_BITS:0]   m_t_in;
  logic [FRAC_BITS:0]   m_t_out;
  logic                 m_ok;

  always_comb begin
    t_in_c  = '0;
    t_out_c = T_ONE;
    if (!side.x.par) begin
      if (ta_x > t_in_c) t_in_c = ta_x;
      if (tb_x < t_out_c) t_out_c = tb_x;
    end
    if (!side.y.par) begin
      if (ta_y > t_in_c) t_in_c = ta_y;
      if (tb_y < t_out_c) t_out_c = tb_y;
    end
    ok_c = side.par_ok && !(t_in_c > t_out_c);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_side  <= side;
      m_t_in  <= t_in_c[FRAC_BITS:0];
      m_t_out <= t_out_c[FRAC_BITS:0];
      m_ok    <= ok_c;
    end
  end

  // multiply stage
  logic                 p_valid;
  side_t                p_side;
  logic                 p_ok;
  logic signed [PW-1:0] p_xi;
  logic signed [PW-1:0] p_yi;
  logic signed [PW-1:0] p_xo;
  logic signed [PW-1:0] p_yo;

  always_ff @(posedge clk) begin
    if (en) begin
      p_side <= m_side;
      p_ok   <= m_ok;
      p_xi   <= PW'($signed({1'b0, m_t_in}) * m_side.x.delta);
      p_yi   <= PW'($signed({1'b0, m_t_in}) * m_side.y.delta);
      p_xo   <= PW'($signed({1'b0, m_t_out}) * m_side.x.delta);
      p_yo   <= PW'($signed({1'b0, m_t_out}) * m_side.y.delta);
    end
  end

  // start + floor(t*d + half)
  function automatic coord_t lerp(coord_t s, logic signed [PW-1:0] p);
    logic signed [PW-1:0] v;
    v = (p + T_HALF) >>> FRAC_BITS;
    v = v + PW'(s);
    return v[COORD_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      m_valid   <= in_valid;
      p_valid   <= m_valid;
      out_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out.visible      <= p_ok;
      out.clip_start_x <= p_ok ? lerp(p_side.x.start, p_xi) : '0;
      out.clip_start_y <= p_ok ? lerp(p_side.y.start, p_yi) : '0;
      out.clip_end_x   <= p_ok ? lerp(p_side.x.start, p_xo) : '0;
      out.clip_end_y   <= p_ok ? lerp(p_side.y.start, p_yo) : '0;
    end
  end

endmodule

@@ rtl/line_segment_clip_rect.sv @@
// top level: segment clipper against a window, with register port
// throughput: one segment per cycle unless the output stalls; the divider gives one quotient bit per stage
// the whole pipeline holds while a result waits on the output register
// reset clears all valid bits and sets the window to left 0, right 32767,
// bottom 0, top 32767
module line_segment_clip_rect #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           seg_valid,
  output logic           seg_ready,
  input  lsc_pkg::seg_t  seg,
  output logic           clip_valid,
  input  logic           clip_ready,
  output lsc_pkg::clip_t clip,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import lsc_pkg::*;

  localparam int TW = FRAC_BITS + 2;

  window_t  win;
  reg_idx_t idx;
  logic     en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      win.left   <= '0;
      win.right  <= COORD_BITS'(32767);
      win.bottom <= '0;
      win.top    <= COORD_BITS'(32767);
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_LEFT:   win.left   <= pwdata[COORD_BITS-1:0];
        REG_RIGHT:  win.right  <= pwdata[COORD_BITS-1:0];
        REG_BOTTOM: win.bottom <= pwdata[COORD_BITS-1:0];
        REG_TOP:    win.top    <= pwdata[COORD_BITS-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LEFT:   prdata = 32'(unsigned'(win.left));
      REG_RIGHT:  prdata = 32'(unsigned'(win.right));
      REG_BOTTOM: prdata = 32'(unsigned'(win.bottom));
      REG_TOP:    prdata = 32'(unsigned'(win.top));
      default:    prdata = '0;
    endcase
  end

  assign en        = !clip_valid || clip_ready;
  assign seg_ready = en;

  logic  f_valid;
  side_t f_side;
  lane_t ax, bx, ay, by;

  lsc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .seg_valid (seg_valid),
    .seg       (seg),
    .win       (win),
    .valid     (f_valid),
    .side      (f_side),
    .ax        (ax),
    .bx        (bx),
    .ay        (ay),
    .by        (by)
  );

  logic signed [TW-1:0] ta_x, tb_x, ta_y, tb_y;

  lsc_div #(.FRAC_BITS(FRAC_BITS)) u_div_ax (.clk(clk), .en(en), .lane(ax), .t(ta_x));
  lsc_div #(.FRAC_BITS(FRAC_BITS)) u_div_bx (.clk(clk), .en(en), .lane(bx), .t(tb_x));
  lsc_div #(.FRAC_BITS(FRAC_BITS)) u_div_ay (.clk(clk), .en(en), .lane(ay), .t(ta_y));
  lsc_div #(.FRAC_BITS(FRAC_BITS)) u_div_by (.clk(clk), .en(en), .lane(by), .t(tb_y));

  logic  d_valid;
  side_t d_side;

  lsc_delay #(.DEPTH(FRAC_BITS + 1)) u_delay (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .in_side   (f_side),
    .out_valid (d_valid),
    .out_side  (d_side)
  );

  lsc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid),
    .side      (d_side),
    .ta_x      (ta_x),
    .tb_x      (tb_x),
    .ta_y      (ta_y),
    .tb_y      (tb_y),
    .out_valid (clip_valid),
    .out       (clip)
  );

endmodule
